/* sv/frame_mean_variance_deviation_macros.svh */
// Assertion macros for the frame statistics block
`ifndef FRAME_MEAN_VARIANCE_DEVIATION_MACROS_SVH
`define FRAME_MEAN_VARIANCE_DEVIATION_MACROS_SVH

// same-cycle implication, reset masked
`define FMVD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, reset masked
`define FMVD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/fmvd_pkg.sv */
// Package: codes, widths and types of the frame statistics block
package fmvd_pkg;
	localparam int SampleBits = 16;
	localparam int ValBits    = 48;
	localparam int CountBits  = 17;
	localparam logic [CountBits-1:0] MaxFrame = 17'd65536;

	typedef logic [2:0] stat_sel_t;
	localparam stat_sel_t SEL_MEAN    = 3'd0;
	localparam stat_sel_t SEL_ABSMEAN = 3'd1;
	localparam stat_sel_t SEL_SVAR    = 3'd2;
	localparam stat_sel_t SEL_PVAR    = 3'd3;
	localparam stat_sel_t SEL_SSD     = 3'd4;
	localparam stat_sel_t SEL_PSD     = 3'd5;

	typedef logic [1:0] status_t;
	localparam status_t ST_OK    = 2'd0;
	localparam status_t ST_FEW   = 2'd1;
	localparam status_t ST_SAT   = 2'd2;

	localparam logic CFG_SELECT = 1'b0;
	localparam logic CFG_SCALE  = 1'b1;
endpackage

/* sv/frame_mean_variance_deviation.sv */
// Top level: frame mean, variance and standard deviation with a shared sequential datapath
//
// channel  dir  tdata                     tuser       tlast
// s_*      in   [15:0] sample             -           last_sample
// m_*      out  [47:0] stat_value (Q.16)  [1:0] status -
// cfg_*    in   write port: index 0 stat_select, 1 mean_scale
//
// A sample that does not end a frame is accumulated and s_tready stays high.
// Frame end: means are formed in setup; variance runs setup, shift-add multiplies, a restoring
// divide and output; deviation adds square-root steps. Reset sets mean_scale to 65536.
// s_tready is low from frame end until the result word is in the output register.
// A result waiting on m_tready stalls only the next frame end. Reset clears all other state.
`include "frame_mean_variance_deviation_macros.svh"
module frame_mean_variance_deviation (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // sample
	input  logic        s_tlast,   // last_sample
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // stat_value
	output logic [1:0]  m_tuser,   // status
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [16:0] cfg_wdata
);
	import fmvd_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE, S_SETUP, S_MULA, S_MULB, S_DIV, S_SQRT, S_DONE
	} state_t;

	state_t             state_q;
	stat_sel_t          sel_q;
	logic [16:0]        scale_q;
	logic signed [32:0] sum_q;
	logic [31:0]        abs_q;
	logic [46:0]        sq_q;
	logic [CountBits-1:0] cnt_q;
	logic [63:0]        acc_q;
	logic [63:0]        mcand_q;
	logic [31:0]        mplier_q;
	logic [32:0]        den_q;
	logic [95:0]        dvd_q;
	logic [51:0]        rem_q;
	logic [47:0]        root_q;
	logic [6:0]         step_q;
	logic [ValBits-1:0] res_q;
	status_t            stat_q;
	logic               mvalid_q;

	logic signed [15:0] smp;
	logic [15:0]        smag;
	logic [CountBits-1:0] cnt_nx;
	logic               s_acc;
	logic [31:0]        sum_mag;
	logic signed [32:0] mean_op;
	logic signed [50:0] mean_prod;
	logic               sample_kind;
	logic               is_sd;
	logic [32:0]        den_full;
	logic [33:0]        div_r2;
	logic               div_ge;
	logic [95:0]        quot;
	logic [51:0]        sq_r2;
	logic [51:0]        sq_trial;
	logic               sq_ge;

	assign s_tready = (state_q == S_IDLE);
	assign s_acc    = s_tvalid && s_tready;
	assign smp      = $signed(s_tdata);
	assign smag     = smp[15] ? 16'(-smp) : s_tdata;
	assign cnt_nx   = cnt_q + 1'b1;
	assign sum_mag  = sum_q[32] ? 32'(-sum_q) : sum_q[31:0];
	assign mean_op  = (sel_q == SEL_MEAN) ? sum_q : $signed({1'b0, abs_q});
	assign mean_prod = mean_op * $signed({1'b0, scale_q});
	assign sample_kind = (sel_q == SEL_SVAR) || (sel_q == SEL_SSD);
	assign is_sd    = (sel_q == SEL_SSD) || (sel_q == SEL_PSD);
	assign den_full = cnt_q * (sample_kind ? cnt_q - 1'b1 : cnt_q);
	assign div_r2   = {rem_q[32:0], dvd_q[95]};
	assign div_ge   = div_r2 >= {1'b0, den_q};
	assign quot     = {dvd_q[94:0], div_ge};
	assign sq_r2    = {rem_q[49:0], dvd_q[95:94]};
	assign sq_trial = {2'b00, root_q, 2'b01};
	assign sq_ge    = sq_r2 >= sq_trial;

	assign m_tvalid = mvalid_q;
	assign m_tdata  = res_q;
	assign m_tuser  = stat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			sel_q    <= SEL_MEAN;
			scale_q  <= 17'd65536;
			sum_q    <= '0;
			abs_q    <= '0;
			sq_q     <= '0;
			cnt_q    <= '0;
			mvalid_q <= 1'b0;
			step_q   <= '0;
			stat_q   <= ST_OK;
			res_q    <= '0;
			den_q    <= '0;
			acc_q    <= '0;
			mcand_q  <= '0;
			mplier_q <= '0;
			dvd_q    <= '0;
			rem_q    <= '0;
			root_q   <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_SELECT: sel_q   <= cfg_wdata[2:0];
					CFG_SCALE:  scale_q <= cfg_wdata;
					default:    ;
				endcase
			end
			if (mvalid_q && m_tready)
				mvalid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (s_acc) begin
						sum_q <= sum_q + 33'(smp);
						abs_q <= abs_q + 32'(smag);
						sq_q  <= sq_q + 47'(smag * smag);
						cnt_q <= cnt_nx;
						if (s_tlast || cnt_nx == MaxFrame)
							state_q <= S_SETUP;
					end
				end
				S_SETUP: begin
					// wait until the output word is free
					if (!mvalid_q || m_tready) begin
						stat_q   <= ST_OK;
						res_q    <= '0;
						den_q    <= den_full;
						acc_q    <= '0;
						mcand_q  <= {17'd0, sq_q};
						mplier_q <= {15'd0, cnt_q};
						step_q   <= 7'd17;
						state_q  <= S_DONE;
						if (sel_q == SEL_MEAN || sel_q == SEL_ABSMEAN) begin
							if (mean_prod[50:47] != {4{mean_prod[47]}}) begin
								stat_q <= ST_SAT;
								res_q  <= mean_prod[50] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
							end else
								res_q <= mean_prod[47:0];
						end else if (sel_q > SEL_PSD) begin
							state_q <= S_DONE;
						end else if (sample_kind && cnt_q < 17'd2) begin
							stat_q <= ST_FEW;
						end else
							state_q <= S_MULA;
					end
				end
				S_MULA, S_MULB: begin
					if (mplier_q[0])
						acc_q <= (state_q == S_MULA) ? acc_q + mcand_q : acc_q - mcand_q;
					mcand_q  <= {mcand_q[62:0], 1'b0};
					mplier_q <= {1'b0, mplier_q[31:1]};
					step_q   <= step_q - 1'b1;
					if (step_q == 7'd1) begin
						if (state_q == S_MULA) begin
							mcand_q  <= {32'd0, sum_mag};
							mplier_q <= sum_mag;
							step_q   <= 7'd32;
							state_q  <= S_MULB;
						end else begin
							step_q  <= 7'd96;
							rem_q   <= '0;
							state_q <= S_DIV;
						end
					end
				end
				S_DIV: begin
					if (step_q == 7'd96)
						dvd_q <= is_sd ? {acc_q, 32'd0} : {16'd0, acc_q, 16'd0};
					else begin
						rem_q[32:0] <= div_ge ? 33'(div_r2 - {1'b0, den_q}) : div_r2[32:0];
						dvd_q <= quot;
					end
					step_q <= step_q - 1'b1;
					if (step_q == 7'd0) begin
						rem_q  <= '0;
						root_q <= '0;
						step_q <= 7'd48;
						if (is_sd)
							state_q <= S_SQRT;
						else begin
							state_q <= S_DONE;
							if (quot[95:47] != '0) begin
								stat_q <= ST_SAT;
								res_q  <= {1'b0, {47{1'b1}}};
							end else
								res_q <= quot[47:0];
						end
					end
				end
				S_SQRT: begin
					if (step_q == 7'd0) begin
						state_q <= S_DONE;
						if (root_q[47]) begin
							stat_q <= ST_SAT;
							res_q  <= {1'b0, {47{1'b1}}};
						end else
							res_q <= root_q;
					end else begin
						rem_q  <= sq_ge ? sq_r2 - sq_trial : sq_r2;
						root_q <= {root_q[46:0], sq_ge};
						dvd_q  <= {dvd_q[93:0], 2'b00};
						step_q <= step_q - 1'b1;
					end
				end
				S_DONE: begin
					if (!mvalid_q || m_tready) begin
						mvalid_q <= 1'b1;
						sum_q    <= '0;
						abs_q    <= '0;
						sq_q     <= '0;
						cnt_q    <= '0;
						state_q  <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`FMVD_ASSERT_NEXT(a_end_blocks, s_tvalid && s_tready && s_tlast, !s_tready, "frame end not taken")
	`FMVD_ASSERT_NOW(a_status_code, m_tvalid, m_tuser != 2'd3, "bad status code")
	`FMVD_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result word changed while waiting")
	`FMVD_ASSERT_NOW(a_div_den, state_q == S_DIV, den_q != '0, "zero divisor")

endmodule
